// ----- hw/rtl/hash_ring_shard_lookup_assert.svh -----
// Assertion macros used by the checker file of the shard lookup block.
`ifndef HASH_RING_SHARD_LOOKUP_ASSERT_SVH
`define HASH_RING_SHARD_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrsl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrsl assertion failed");

`endif

// ----- hw/rtl/hrsl_pkg.sv -----
// Shared types and constants of the hash ring shard lookup block.
package hrsl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SHARD_COUNT = 128;
  localparam int HASH_W      = 32;
  localparam int SHARD_W     = 7;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_COMPARE,
    S_LOOK_RD,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SHARD_W-1:0] shard;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;         // capture the input transfer
    logic    clr_count;    // empty the table
    logic    srch_init;    // lo = 0, hi = count
    logic    rd_mid;       // read entry at search midpoint
    logic    srch_step;    // narrow the search window
    logic    rd_lo;        // read the lookup hit (or entry 0 on wrap)
    logic    ptr_init;     // shift pointer = count
    logic    shift_rd;     // read entry ptr-1
    logic    shift_wr;     // write that entry to ptr, ptr--
    logic    ins_write;    // write new entry at lo, count++
    logic    emit;         // load the result register
    logic    emit_lookup;  // result carries the read shard and wrap flag
    status_e emit_st;
  } hrsl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_e action;
    logic empty;
    logic full;
    logic srch_done;   // lo == hi
    logic shift_done;  // ptr == lo
  } hrsl_sts_t;

endpackage

// ----- hw/rtl/hrsl_ctrl.sv -----
// Sequencing state machine of the hash ring shard lookup block.
module hrsl_ctrl
  import hrsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  hrsl_sts_t sts_i,
  output hrsl_cmd_t cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.action)
          ACT_INSERT: state_d = sts_i.full  ? S_IDLE : S_SEARCH;
          ACT_LOOKUP: state_d = sts_i.empty ? S_IDLE : S_SEARCH;
          default:    state_d = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (!sts_i.srch_done) begin
          state_d = S_COMPARE;
        end else if (sts_i.action == ACT_LOOKUP) begin
          state_d = S_LOOK_RD;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_COMPARE:  state_d = S_SEARCH;
      S_LOOK_RD:  state_d = S_IDLE;
      S_SHIFT_RD: state_d = sts_i.shift_done ? S_IDLE : S_SHIFT_WR;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.emit_st = ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_DISPATCH: begin
        case (sts_i.action)
          ACT_CLEAR: begin
            cmd_o.clr_count = 1'b1;
            cmd_o.emit      = 1'b1;
          end
          ACT_INSERT: begin
            if (sts_i.full) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_st = ST_FULL;
            end else begin
              cmd_o.srch_init = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            if (sts_i.empty) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_st = ST_EMPTY;
            end else begin
              cmd_o.srch_init = 1'b1;
            end
          end
          default: begin
            cmd_o.emit = 1'b1;
          end
        endcase
      end
      S_SEARCH: begin
        if (!sts_i.srch_done) begin
          cmd_o.rd_mid = 1'b1;
        end else if (sts_i.action == ACT_LOOKUP) begin
          cmd_o.rd_lo = 1'b1;
        end else begin
          cmd_o.ptr_init = 1'b1;
        end
      end
      S_COMPARE: begin
        cmd_o.srch_step = 1'b1;
      end
      S_LOOK_RD: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_lookup = 1'b1;
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_done) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.emit      = 1'b1;
        end else begin
          cmd_o.shift_rd = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
      end
      default: begin
        cmd_o.emit_st = ST_OK;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/hrsl_dpath.sv -----
// Datapath of the hash ring shard lookup block: table memory, search window, result.
module hrsl_dpath
  import hrsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         action_i,
  input  logic [HASH_W-1:0]  hash_value_i,
  input  logic [SHARD_W-1:0] shard_in_i,
  input  hrsl_cmd_t          cmd_i,
  output hrsl_sts_t          sts_o,
  output logic               done_o,
  output logic [SHARD_W-1:0] shard_out_o,
  output logic               wrapped_o,
  output logic [1:0]         status_o
);

  entry_t mem [TABLE_DEPTH];

  act_e               action_q;
  logic [HASH_W-1:0]  hash_q;
  logic [SHARD_W-1:0] shard_q;
  logic [CNT_W-1:0]   count_q, lo_q, hi_q, ptr_q;
  logic               wrap_q;
  entry_t             rd_data_q;
  logic               done_q;
  logic [SHARD_W-1:0] shard_out_q;
  logic               wrapped_q;
  status_e            status_q;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid, mid_p1, ptr_m1;
  logic               at_end, go_left;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  entry_t             mem_wdata;

  // Search window arithmetic
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CNT_W:1];
  assign mid_p1  = mid + CNT_W'(1);
  assign ptr_m1  = ptr_q - CNT_W'(1);
  assign at_end  = (lo_q == count_q);

  // Lookup seeks the first hash >= key; insert seeks the first hash > new hash
  assign go_left = (action_q == ACT_LOOKUP) ? (rd_data_q.hash >= hash_q)
                                            : (rd_data_q.hash > hash_q);

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= act_e'(action_i);
      hash_q   <= hash_value_i;
      shard_q  <= shard_in_i;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clr_count) begin
      count_q <= '0;
    end else if (cmd_i.ins_write) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Search window and shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= count_q;
    end else if (cmd_i.srch_step) begin
      if (go_left) hi_q <= mid;
      else         lo_q <= mid_p1;
    end
    if (cmd_i.ptr_init) begin
      ptr_q <= count_q;
    end else if (cmd_i.shift_wr) begin
      ptr_q <= ptr_m1;
    end
    if (cmd_i.rd_lo) begin
      wrap_q <= at_end;
    end
  end

  // Memory port selection
  always_comb begin
    mem_re    = cmd_i.rd_mid | cmd_i.rd_lo | cmd_i.shift_rd;
    mem_raddr = ptr_m1[IDX_W-1:0];
    if (cmd_i.rd_mid) begin
      mem_raddr = mid[IDX_W-1:0];
    end else if (cmd_i.rd_lo) begin
      mem_raddr = at_end ? '0 : lo_q[IDX_W-1:0];
    end
    mem_we    = cmd_i.shift_wr | cmd_i.ins_write;
    mem_waddr = cmd_i.shift_wr ? ptr_q[IDX_W-1:0] : lo_q[IDX_W-1:0];
    mem_wdata = cmd_i.shift_wr ? rd_data_q : entry_t'{hash: hash_q, shard: shard_q};
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q    <= cmd_i.emit_st;
      shard_out_q <= cmd_i.emit_lookup ? rd_data_q.shard : '0;
      wrapped_q   <= cmd_i.emit_lookup & wrap_q;
    end
  end

  // Status to controller
  assign sts_o.action     = action_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CNT_W'(TABLE_DEPTH));
  assign sts_o.srch_done  = (lo_q == hi_q);
  assign sts_o.shift_done = (ptr_q == lo_q);

  assign done_o      = done_q;
  assign shard_out_o = shard_out_q;
  assign wrapped_o   = wrapped_q;
  assign status_o    = status_q;

endmodule

// ----- hw/rtl/hash_ring_shard_lookup.sv -----
// Top level of the hash ring shard lookup block.
// A command transfers when start_i is high while busy_o is low; busy_o stays high until the
// command's single result has been loaded, and done_o then marks that result for exactly one
// cycle, which the receiver must take as it comes. Clear, unused codes, insert into a full
// table and lookup on an empty table load their result straight from the dispatch state. A
// lookup runs a binary search over the N stored entries, with a read state and a compare
// state per step, then reads the hit. An insert runs the same search and then moves every
// entry above its slot up by one, with a read and a write per moved entry. The table is a
// single memory with a registered read. No clearing pass is needed after reset.
module hash_ring_shard_lookup
  import hrsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic [HASH_W-1:0]  hash_value_i,
  input  logic [SHARD_W-1:0] shard_in_i,
  output logic               done_o,
  output logic [SHARD_W-1:0] shard_out_o,
  output logic               wrapped_o,
  output logic [1:0]         status_o
);

  hrsl_cmd_t cmd;
  hrsl_sts_t sts;

  hrsl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  hrsl_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .hash_value_i (hash_value_i),
    .shard_in_i   (shard_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .shard_out_o  (shard_out_o),
    .wrapped_o    (wrapped_o),
    .status_o     (status_o)
  );

endmodule

// ----- hw/rtl/hrsl_checker.sv -----
// Port-level assertions for the hash ring shard lookup block, with its bind.
`include "hash_ring_shard_lookup_assert.svh"

module hrsl_checker
  import hrsl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [SHARD_W-1:0] shard_out_o,
  input logic               wrapped_o,
  input logic [1:0]         status_o
);

  logic accept;
  assign accept = start_i & !busy_o;

  // A command transfer makes the block busy
  `HRSL_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy_o)
  // A result is only shown once the command is finished
  `HRSL_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  // One result per command: strobes never come back to back
  `HRSL_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // Error results carry no shard and no wrap flag
  `HRSL_ASSERT_IMP(a_err_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), (shard_out_o == '0) && !wrapped_o && ((status_o == ST_EMPTY) || (status_o == ST_FULL)))

endmodule

bind hash_ring_shard_lookup hrsl_checker u_hrsl_checker (.*);
